// File: rtl/i2cm_pkg.sv
// Package for the I2C master byte engine: command codes, phase counts,
// the step result type and small decode helpers. No dependencies.
`default_nettype none

package i2cm_pkg;

    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 5;
    localparam int BITC_W  = 4;
    localparam int TICK_W  = 8;

    localparam logic [CMD_W-1:0] OP_IDLE  = 3'd0;
    localparam logic [CMD_W-1:0] OP_START = 3'd1;
    localparam logic [CMD_W-1:0] OP_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] OP_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] OP_READ  = 3'd4;
    localparam logic [CMD_W-1:0] OP_ACK   = 3'd5;
    localparam logic [CMD_W-1:0] OP_NACK  = 3'd6;

    localparam logic [BYTE_W-1:0] PHASE_TICKS_RST = 8'd5;

    // write and read sequence landmarks
    localparam logic [PHASE_W-1:0] WR_ACK_SDA  = 5'd24;
    localparam logic [PHASE_W-1:0] WR_ACK_HIGH = 5'd25;
    localparam logic [PHASE_W-1:0] RD_LAST     = 5'd17;
    localparam logic [PHASE_W-1:0] RD_FIRST_HI = 5'd2;
    localparam logic [PHASE_W-1:0] RD_LAST_HI  = 5'd16;

    localparam logic [1:0] WR_SET_SDA = 2'd0;
    localparam logic [1:0] WR_SCL_HI  = 2'd1;
    localparam logic [1:0] WR_SCL_LO  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] rd_byte;
        logic              ack_received;
        logic              done_res;
        logic              busy_res;
        logic              sda_level;
        logic              scl_level;
    } res_t;

    function automatic logic [PHASE_W-1:0] phase_total(input logic [CMD_W-1:0] op);
        logic [PHASE_W-1:0] t;
        begin
            unique case (op)
                OP_START: t = 5'd4;
                OP_STOP:  t = 5'd3;
                OP_WRITE: t = 5'd27;
                OP_READ:  t = 5'd18;
                OP_ACK:   t = 5'd3;
                OP_NACK:  t = 5'd3;
                default:  t = 5'd0;
            endcase
            return t;
        end
    endfunction

    // position of a write phase within its three-phase bit slot
    function automatic logic [1:0] wr_slot(input logic [PHASE_W-1:0] idx);
        logic [1:0] r;
        begin
            unique case (idx)
                5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27,
                5'd30:
                    r = WR_SET_SDA;
                5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25, 5'd28,
                5'd31:
                    r = WR_SCL_HI;
                default:
                    r = WR_SCL_LO;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/i2cm_seq.sv
// Bus phase sequencer: holds the command state and advances it by one tick
// per enabled cycle, giving that tick's result. Uses i2cm_pkg.
`default_nettype none

module i2cm_seq
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step_en,
    input  wire logic [i2cm_pkg::CMD_W-1:0]    cmd,
    input  wire logic [i2cm_pkg::BYTE_W-1:0]   wr_byte,
    input  wire logic                          sda_in,
    input  wire logic [i2cm_pkg::TICK_W-1:0]   phase_ticks,
    output i2cm_pkg::res_t                     res
);

    logic [i2cm_pkg::CMD_W-1:0]   op_reg,    op_next;
    logic [i2cm_pkg::PHASE_W-1:0] idx_reg,   idx_next;
    logic [i2cm_pkg::BITC_W-1:0]  bitc_reg,  bitc_next;
    logic [i2cm_pkg::BYTE_W-1:0]  shift_reg, shift_next;
    logic [i2cm_pkg::TICK_W-1:0]  tick_reg,  tick_next;
    logic                         scl_reg,   scl_next;
    logic                         sda_reg,   sda_next;
    logic                         ack_reg,   ack_next;
    logic [i2cm_pkg::BYTE_W-1:0]  rdh_reg,   rdh_next;

    logic [i2cm_pkg::TICK_W-1:0]  limit;
    logic                         do_enter;
    logic                         done;

    always_comb
    begin
        limit      = (phase_ticks == '0) ? i2cm_pkg::TICK_W'(1) : phase_ticks;
        op_next    = op_reg;
        idx_next   = idx_reg;
        bitc_next  = bitc_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rdh_next   = rdh_reg;
        do_enter   = 1'b0;
        done       = 1'b0;

        if (op_reg == i2cm_pkg::OP_IDLE)
        begin
            if (cmd >= i2cm_pkg::OP_START && cmd <= i2cm_pkg::OP_NACK)
            begin
                op_next    = cmd;
                idx_next   = '0;
                bitc_next  = '0;
                tick_next  = '0;
                shift_next = (cmd == i2cm_pkg::OP_WRITE) ? wr_byte : '0;
                do_enter   = 1'b1;
            end
        end
        else
        begin
            tick_next = tick_reg + i2cm_pkg::TICK_W'(1);
            if (tick_next >= limit)
            begin
                if (op_reg == i2cm_pkg::OP_WRITE && idx_reg == i2cm_pkg::WR_ACK_HIGH)
                begin
                    ack_next = ~sda_in;
                end
                else if (op_reg == i2cm_pkg::OP_READ && !idx_reg[0] &&
                         idx_reg >= i2cm_pkg::RD_FIRST_HI && idx_reg <= i2cm_pkg::RD_LAST_HI)
                begin
                    shift_next = {shift_reg[i2cm_pkg::BYTE_W-2:0], sda_in};
                    bitc_next  = bitc_reg + i2cm_pkg::BITC_W'(1);
                end
                idx_next  = idx_reg + i2cm_pkg::PHASE_W'(1);
                tick_next = '0;
                if (idx_next >= i2cm_pkg::phase_total(op_reg))
                begin
                    if (op_reg == i2cm_pkg::OP_READ)
                    begin
                        rdh_next = shift_next;
                    end
                    op_next  = i2cm_pkg::OP_IDLE;
                    idx_next = '0;
                    done     = 1'b1;
                end
                else
                begin
                    do_enter = 1'b1;
                end
            end
        end

        // pin change that opens phase idx_next of op_next
        if (do_enter)
        begin
            unique case (op_next)
                i2cm_pkg::OP_START:
                begin
                    unique case (idx_next)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                i2cm_pkg::OP_STOP:
                begin
                    unique case (idx_next)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                i2cm_pkg::OP_WRITE:
                begin
                    if (idx_next < i2cm_pkg::WR_ACK_SDA)
                    begin
                        unique case (i2cm_pkg::wr_slot(idx_next))
                            i2cm_pkg::WR_SET_SDA:
                            begin
                                sda_next   = shift_next[i2cm_pkg::BYTE_W-1];
                                shift_next = {shift_next[i2cm_pkg::BYTE_W-2:0], 1'b0};
                                bitc_next  = bitc_next + i2cm_pkg::BITC_W'(1);
                            end
                            i2cm_pkg::WR_SCL_HI: scl_next = 1'b1;
                            default:             scl_next = 1'b0;
                        endcase
                    end
                    else if (idx_next == i2cm_pkg::WR_ACK_SDA)
                    begin
                        sda_next = 1'b1;
                    end
                    else if (idx_next == i2cm_pkg::WR_ACK_HIGH)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                i2cm_pkg::OP_READ:
                begin
                    if (idx_next == '0)
                    begin
                        sda_next = 1'b1;
                    end
                    else if (idx_next == i2cm_pkg::RD_LAST)
                    begin
                        scl_next = 1'b0;
                    end
                    else
                    begin
                        scl_next = ~idx_next[0];
                    end
                end
                i2cm_pkg::OP_ACK, i2cm_pkg::OP_NACK:
                begin
                    if (idx_next == '0)
                    begin
                        sda_next = (op_next == i2cm_pkg::OP_NACK);
                    end
                    else if (idx_next == 5'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.scl_level    = scl_next;
        res.sda_level    = sda_next;
        res.busy_res     = (op_next != i2cm_pkg::OP_IDLE);
        res.done_res     = done;
        res.ack_received = ack_next;
        res.rd_byte      = rdh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= i2cm_pkg::OP_IDLE;
            idx_reg   <= '0;
            bitc_reg  <= '0;
            shift_reg <= '0;
            tick_reg  <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            rdh_reg   <= '0;
        end
        else if (step_en)
        begin
            op_reg    <= op_next;
            idx_reg   <= idx_next;
            bitc_reg  <= bitc_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rdh_reg   <= rdh_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: stream ports, APB register and
// output register. Uses i2cm_pkg and i2cm_seq.
`default_nettype none

// Each input word is one bus tick and yields exactly one result word, in the
// cycle after it is taken. A word is accepted every clock while the result
// side keeps up: the single output register is refilled in the same cycle it
// is drained, so throughput is one word per clock, set by the one-tick
// sequencer step. Commands are taken only while idle; a command word that
// arrives while busy counts as a plain tick. Phase length comes from the
// phase_ticks register at address 0 (0 behaves as 1).
module i2c_master_byte_engine
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // cmd[2:0], wr_byte[10:3], sda_in[11], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,  // scl_level, sda_level, busy_res, done_res,
                                       // ack_received, rd_byte[12:5], zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [i2cm_pkg::TICK_W-1:0] phase_ticks_reg;
    logic                        m_valid_reg;
    i2cm_pkg::res_t              res_reg;
    i2cm_pkg::res_t              res;
    logic                        step_en;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {24'd0, phase_ticks_reg} : 32'd0;
    assign s_tready = !m_valid_reg || m_tready;
    assign step_en  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RST;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            phase_ticks_reg <= pwdata[i2cm_pkg::TICK_W-1:0];
        end
    end

    i2cm_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .cmd         (s_tdata[2:0]),
        .wr_byte     (s_tdata[10:3]),
        .sda_in      (s_tdata[11]),
        .phase_ticks (phase_ticks_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// File: verif/tb.sv
// Testbench for i2c_master_byte_engine: drives bus ticks on the input stream,
// predicts every result word with its own sequencer copy and checks it.
// Depends on i2cm_pkg and the RTL of the engine only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int GAP_PCT     = 23;

    localparam logic [2:0] ADDR_PHASE_TICKS = 3'd0;
    localparam logic [2:0] CMD_UNUSED       = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // cmd[2:0], wr_byte[10:3], sda_in[11], zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // scl_level, sda_level, busy_res, done_res,
                                   // ack_received, rd_byte[12:5], zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_byte_engine u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // sequencer copy
    logic [7:0] period_cfg = i2cm_pkg::PHASE_TICKS_RST;
    logic [2:0] seq_op     = i2cm_pkg::OP_IDLE;
    logic [4:0] seq_phase  = '0;
    logic [7:0] hold_cnt   = '0;
    logic [7:0] shreg      = '0;
    logic       scl_q      = 1'b1;
    logic       sda_q      = 1'b1;
    logic       ack_q      = 1'b0;
    logic [7:0] rd_q       = '0;

    i2cm_pkg::res_t bus_expect[$];
    int   errs       = 0;
    int   cycles     = 0;
    int   ticks_sent = 0;
    bit   steady     = 1'b0;

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        i2cm_pkg::res_t got;
        i2cm_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = i2cm_pkg::res_t'(m_tdata[12:0]);
            if (bus_expect.size() == 0)
            begin
                $error("result word with nothing expected: %h", m_tdata);
                errs++;
            end
            else
            begin
                want = bus_expect.pop_front();
                if (got.scl_level !== want.scl_level)
                begin
                    $error("scl_level: expected %0d, got %0d", want.scl_level, got.scl_level);
                    errs++;
                end
                if (got.sda_level !== want.sda_level)
                begin
                    $error("sda_level: expected %0d, got %0d", want.sda_level, got.sda_level);
                    errs++;
                end
                if (got.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                    errs++;
                end
                if (got.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                    errs++;
                end
                if (got.ack_received !== want.ack_received)
                begin
                    $error("ack_received: expected %0d, got %0d",
                           want.ack_received, got.ack_received);
                    errs++;
                end
                if (got.rd_byte !== want.rd_byte)
                begin
                    $error("rd_byte: expected %0h, got %0h", want.rd_byte, got.rd_byte);
                    errs++;
                end
            end
        end
        m_tready <= steady || ($urandom_range(99) >= GAP_PCT);
    end

    // pin change at the start of the current phase
    function automatic void drive_pins();
        case (seq_op)
            i2cm_pkg::OP_START:
                case (seq_phase)
                    5'd0:    sda_q = 1'b1;
                    5'd1:    scl_q = 1'b1;
                    5'd2:    sda_q = 1'b0;
                    default: scl_q = 1'b0;
                endcase
            i2cm_pkg::OP_STOP:
                case (seq_phase)
                    5'd0:    sda_q = 1'b0;
                    5'd1:    scl_q = 1'b1;
                    default: sda_q = 1'b1;
                endcase
            i2cm_pkg::OP_WRITE:
                if (seq_phase == 5'd24)
                    sda_q = 1'b1;
                else if (seq_phase > 5'd24)
                    scl_q = (seq_phase == 5'd25);
                else
                    case (seq_phase % 3)
                        5'd0:
                        begin
                            sda_q = shreg[7];
                            shreg = {shreg[6:0], 1'b0};
                        end
                        5'd1:    scl_q = 1'b1;
                        default: scl_q = 1'b0;
                    endcase
            i2cm_pkg::OP_READ:
                if (seq_phase == 5'd0)
                    sda_q = 1'b1;
                else if (seq_phase == 5'd17)
                    scl_q = 1'b0;
                else
                    scl_q = ~seq_phase[0];
            default:
                case (seq_phase)
                    5'd0:    sda_q = (seq_op == i2cm_pkg::OP_NACK);
                    5'd1:    scl_q = 1'b1;
                    default: scl_q = 1'b0;
                endcase
        endcase
    endfunction

    task automatic bus_step(input logic [2:0] cmd, input logic [7:0] wr, input logic sda,
                            output i2cm_pkg::res_t r);
        logic [7:0] span;
        logic [4:0] last;
        logic       fin;
        begin
            fin  = 1'b0;
            span = (period_cfg == 8'd0) ? 8'd1 : period_cfg;
            if (seq_op == i2cm_pkg::OP_IDLE)
            begin
                if (cmd >= i2cm_pkg::OP_START && cmd <= i2cm_pkg::OP_NACK)
                begin
                    seq_op    = cmd;
                    seq_phase = '0;
                    hold_cnt  = '0;
                    shreg     = (cmd == i2cm_pkg::OP_WRITE) ? wr : 8'd0;
                    drive_pins();
                end
            end
            else
            begin
                hold_cnt = hold_cnt + 8'd1;
                if (hold_cnt >= span)
                begin
                    if (seq_op == i2cm_pkg::OP_WRITE && seq_phase == 5'd25)
                        ack_q = ~sda;
                    if (seq_op == i2cm_pkg::OP_READ && seq_phase >= 5'd2
                        && seq_phase <= 5'd16 && !seq_phase[0])
                        shreg = {shreg[6:0], sda};
                    case (seq_op)
                        i2cm_pkg::OP_START: last = 5'd3;
                        i2cm_pkg::OP_WRITE: last = 5'd26;
                        i2cm_pkg::OP_READ:  last = 5'd17;
                        default:            last = 5'd2;
                    endcase
                    hold_cnt = '0;
                    if (seq_phase == last)
                    begin
                        if (seq_op == i2cm_pkg::OP_READ)
                            rd_q = shreg;
                        seq_op    = i2cm_pkg::OP_IDLE;
                        seq_phase = '0;
                        fin       = 1'b1;
                    end
                    else
                    begin
                        seq_phase = seq_phase + 5'd1;
                        drive_pins();
                    end
                end
            end
            r              = '0;
            r.scl_level    = scl_q;
            r.sda_level    = sda_q;
            r.busy_res     = (seq_op != i2cm_pkg::OP_IDLE);
            r.done_res     = fin;
            r.ack_received = ack_q;
            r.rd_byte      = rd_q;
        end
    endtask

    task automatic send_word(input logic [2:0] cmd, input logic [7:0] wr, input logic sda);
        i2cm_pkg::res_t r;
        begin
            while (!steady && $urandom_range(99) < GAP_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0000, sda, wr, cmd};
            do
                @(posedge clk);
            while (!s_tready);
            bus_step(cmd, wr, sda, r);
            bus_expect.push_back(r);
            ticks_sent++;
        end
    endtask

    // one command and the ticks that carry it to completion; the slave
    // drives read data MSB first and holds its ack on the line through a write
    task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] wr,
                           input logic [7:0] slave_byte, input logic slave_ack,
                           input bit noisy);
        logic [2:0] stray;
        logic       line;
        int         k;
        begin
            send_word(cmd, wr, ~slave_ack);
            while (seq_op != i2cm_pkg::OP_IDLE)
            begin
                if (seq_op == i2cm_pkg::OP_READ)
                begin
                    k = (seq_phase == 5'd0) ? 0 : (int'(seq_phase) - 1) / 2;
                    if (k > 7)
                        k = 7;
                    line = slave_byte[7 - k];
                end
                else if (seq_op == i2cm_pkg::OP_WRITE)
                    line = ~slave_ack;
                else
                    line = 1'($urandom_range(1));
                if (noisy && $urandom_range(99) < 10)
                    line = ~line;
                stray = (noisy && $urandom_range(99) < 30) ? 3'($urandom_range(7))
                                                           : i2cm_pkg::OP_IDLE;
                send_word(stray, 8'($urandom), line);
            end
        end
    endtask

    task automatic wait_drained();
        begin
            while (bus_expect.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic set_period(input logic [7:0] v);
        begin
            while (seq_op != i2cm_pkg::OP_IDLE)
                send_word(i2cm_pkg::OP_IDLE, 8'($urandom), 1'($urandom_range(1)));
            s_tvalid <= 1'b0;
            wait_drained();
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_PHASE_TICKS;
            pwdata  <= {24'd0, v};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            psel       <= 1'b0;
            penable    <= 1'b0;
            pwrite     <= 1'b0;
            period_cfg = v;
        end
    endtask

    task automatic i2c_transaction(input bit noisy);
        int n;
        begin
            run_cmd(i2cm_pkg::OP_START, 8'($urandom), 8'($urandom), 1'b1, noisy);
            run_cmd(i2cm_pkg::OP_WRITE, 8'($urandom), 8'($urandom),
                    $urandom_range(9) != 0, noisy);
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                if ($urandom_range(1))
                    run_cmd(i2cm_pkg::OP_WRITE, 8'($urandom), 8'($urandom),
                            $urandom_range(5) != 0, noisy);
                else
                begin
                    run_cmd(i2cm_pkg::OP_READ, 8'($urandom), 8'($urandom), 1'b1, noisy);
                    run_cmd($urandom_range(1) ? i2cm_pkg::OP_ACK : i2cm_pkg::OP_NACK,
                            8'($urandom), 8'($urandom), 1'b1, noisy);
                end
            end
            run_cmd(i2cm_pkg::OP_STOP, 8'($urandom), 8'($urandom), 1'b1, noisy);
        end
    endtask

    task automatic test_reset_state();
        begin
            repeat (4) send_word(i2cm_pkg::OP_IDLE, 8'($urandom), 1'($urandom_range(1)));
            repeat (2) send_word(CMD_UNUSED, 8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    // every command and its corner cases; reset phase length first
    task automatic test_commands();
        begin
            run_cmd(i2cm_pkg::OP_START, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_NACK, 8'h00, 8'h00, 1'b1, 1'b0);
            set_period(8'd1);
            run_cmd(i2cm_pkg::OP_WRITE, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0);
            run_cmd(i2cm_pkg::OP_WRITE, 8'hA5, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_READ, 8'h00, 8'hFF, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_ACK, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_READ, 8'hFF, 8'h5A, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_NACK, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_READ, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_STOP, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_STOP, 8'h00, 8'h00, 1'b1, 1'b0);
            // stray commands while busy must be ignored
            run_cmd(i2cm_pkg::OP_START, 8'h00, 8'h00, 1'b1, 1'b1);
            run_cmd(i2cm_pkg::OP_WRITE, 8'h3C, 8'h00, 1'b1, 1'b1);
            run_cmd(CMD_UNUSED, 8'hFF, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_STOP, 8'h00, 8'h00, 1'b1, 1'b1);
        end
    endtask

    task automatic test_phase_lengths();
        begin
            // zero length behaves as one tick
            set_period(8'd0);
            run_cmd(i2cm_pkg::OP_START, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_WRITE, 8'h3C, 8'h00, 1'b0, 1'b0);
            run_cmd(i2cm_pkg::OP_STOP, 8'h00, 8'h00, 1'b1, 1'b0);
            set_period(8'd2);
            run_cmd(i2cm_pkg::OP_START, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_READ, 8'h00, 8'h7E, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_NACK, 8'h00, 8'h00, 1'b1, 1'b0);
            run_cmd(i2cm_pkg::OP_STOP, 8'h00, 8'h00, 1'b1, 1'b0);
        end
    endtask

    task automatic test_random();
        int mark;
        begin
            for (int round = 0; round < 2; round++)
            begin
                set_period(8'(round + 1));
                steady = (round == 1);
                mark   = ticks_sent;
                while (ticks_sent - mark < 60)
                begin
                    if ($urandom_range(99) < 80)
                        i2c_transaction($urandom_range(99) < 20);
                    else
                        repeat ($urandom_range(1, 4))
                            run_cmd(3'($urandom_range(7)), 8'($urandom), 8'($urandom),
                                    1'($urandom_range(1)), 1'b1);
                end
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_commands();
        test_phase_lengths();
        test_random();
        s_tvalid <= 1'b0;
        wait_drained();
        if (errs == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/i2cm_pkg.sv
rtl/i2cm_seq.sv
rtl/i2c_master_byte_engine.sv
verif/tb.sv
